FILE: rtl/soe_pkg.sv
// Shared types and constants for the set operations engine.
// Request codes, field widths and the result item layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package soe_pkg;

    localparam int ELEM_W = 32;
    localparam int REQ_W  = 3;

    // Request codes carried on s_tuser
    localparam logic [REQ_W-1:0] REQ_LOAD_ONE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_TWO = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FIND_ONE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND_TWO = 3'd3;
    localparam logic [REQ_W-1:0] REQ_UNION    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_INTER    = 3'd5;
    localparam logic [REQ_W-1:0] REQ_DIFF     = 3'd6;
    localparam logic [REQ_W-1:0] REQ_NONE     = 3'd7;

    // One result beat as it travels from the sequencer to the output stage
    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              found;
        logic              empty_res;
        logic              status;
        logic              last;
    } soe_item_t;

endpackage

`default_nettype wire

FILE: rtl/soe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read data is registered and appears in the cycle after the address. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module soe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/soe_out.sv
// Output register for the result channel: holds one beat until taken.
// Depends on soe_pkg for the result item type.
`timescale 1ns / 1ps
`default_nettype none

module soe_out (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire soe_pkg::soe_item_t push_item,
    input  wire logic              push,
    output logic                   free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,   // element
    output logic [2:0]             m_tuser,   // found, empty_res, status
    output logic                   m_tlast
);

    import soe_pkg::*;

    logic      valid_reg;
    soe_item_t item_reg;

    // Slot is free when empty or when its beat leaves this cycle
    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            item_reg <= push_item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = item_reg.element;
    assign m_tuser  = {item_reg.status, item_reg.empty_res, item_reg.found};
    assign m_tlast  = item_reg.last;

endmodule

`default_nettype wire

FILE: rtl/soe_ctrl.sv
// Request sequencer: decodes requests, keeps the set counts, drives the two
// set memories and scans them. Depends on soe_pkg; talks to soe_ram and soe_out.
`timescale 1ns / 1ps
`default_nettype none

module soe_ctrl #(
    parameter int SET_CAPACITY = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // request beat
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [soe_pkg::REQ_W-1:0]       req_type,
    input  wire logic [soe_pkg::ELEM_W-1:0]      value,
    input  wire logic                            first,
    // output stage
    input  wire logic                            out_free,
    output logic                                 out_push,
    output soe_pkg::soe_item_t                   out_item,
    // set memories
    output logic                                 we_one,
    output logic                                 we_two,
    output logic [$clog2(SET_CAPACITY)-1:0]      waddr,
    output logic [soe_pkg::ELEM_W-1:0]           wdata,
    output logic [$clog2(SET_CAPACITY)-1:0]      raddr,
    input  wire logic [soe_pkg::ELEM_W-1:0]      rdata_one,
    input  wire logic [soe_pkg::ELEM_W-1:0]      rdata_two
);

    import soe_pkg::*;

    localparam int ADDR_W = $clog2(SET_CAPACITY);
    localparam int CNT_W  = $clog2(SET_CAPACITY + 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOAD    = 3'd1;
    localparam logic [2:0] ST_NEXT    = 3'd2;
    localparam logic [2:0] ST_CAND    = 3'd3;
    localparam logic [2:0] ST_SCAN    = 3'd4;
    localparam logic [2:0] ST_EMIT    = 3'd5;
    localparam logic [2:0] ST_FLUSH   = 3'd6;
    localparam logic [2:0] ST_FINDOUT = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [REQ_W-1:0]  op_reg, op_next;
    logic [ELEM_W-1:0] val_reg, val_next;
    logic              first_reg, first_next;
    logic [CNT_W-1:0]  cnt_one_reg, cnt_one_next;
    logic [CNT_W-1:0]  cnt_two_reg, cnt_two_next;
    logic [CNT_W-1:0]  outer_reg, outer_next;
    logic [CNT_W-1:0]  inner_reg, inner_next;
    logic [CNT_W-1:0]  lim_reg, lim_next;
    logic              pend_reg, pend_next;
    logic              hit_reg, hit_next;
    logic [ELEM_W-1:0] cand_reg, cand_next;
    logic              phase_reg, phase_next;   // union: 0 set one, 1 set two
    logic              sub_reg, sub_next;       // union scan: 0 vs one, 1 vs two
    logic              sel_reg, sel_next;       // memory being read: 1 is set two
    logic              hold_valid_reg, hold_valid_next;
    logic [ELEM_W-1:0] hold_reg, hold_next;

    logic [ELEM_W-1:0] rdata_sel;
    logic [CNT_W-1:0]  load_base;
    logic              load_full;
    logic              keep;

    assign rdata_sel = sel_reg ? rdata_two : rdata_one;
    assign s_tready  = (state_reg == ST_IDLE);

    // Append position: restart empties the set first
    assign load_base = first_reg ? '0 : (op_reg == REQ_LOAD_TWO ? cnt_two_reg : cnt_one_reg);
    assign load_full = (load_base >= CNT_W'(SET_CAPACITY));

    // Whether the current candidate belongs to the answer
    assign keep = (op_reg == REQ_INTER) ? hit_reg : !hit_reg;

    // Next-state logic
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        first_next      = first_reg;
        cnt_one_next    = cnt_one_reg;
        cnt_two_next    = cnt_two_reg;
        outer_next      = outer_reg;
        inner_next      = inner_reg;
        lim_next        = lim_reg;
        pend_next       = pend_reg;
        hit_next        = hit_reg;
        cand_next       = cand_reg;
        phase_next      = phase_reg;
        sub_next        = sub_reg;
        sel_next        = sel_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_push        = 1'b0;
        out_item        = '0;
        we_one          = 1'b0;
        we_two          = 1'b0;
        waddr           = load_base[ADDR_W-1:0];
        wdata           = val_reg;
        raddr           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = req_type;
                    val_next   = value;
                    first_next = first;
                    unique case (req_type) inside
                        REQ_LOAD_ONE, REQ_LOAD_TWO: begin
                            state_next = ST_LOAD;
                        end
                        REQ_FIND_ONE, REQ_FIND_TWO: begin
                            sel_next   = (req_type == REQ_FIND_TWO);
                            lim_next   = (req_type == REQ_FIND_TWO) ? cnt_two_reg : cnt_one_reg;
                            inner_next = '0;
                            pend_next  = 1'b0;
                            hit_next   = 1'b0;
                            cand_next  = value;
                            state_next = ST_SCAN;
                        end
                        REQ_UNION, REQ_INTER, REQ_DIFF: begin
                            outer_next      = '0;
                            phase_next      = 1'b0;
                            hold_valid_next = 1'b0;
                            state_next      = ST_NEXT;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Append (or flag full) and answer in the same cycle
            ST_LOAD: begin
                if (out_free) begin
                    out_push         = 1'b1;
                    out_item.element = val_reg;
                    out_item.status  = load_full;
                    out_item.last    = 1'b1;
                    if (!load_full) begin
                        we_one = (op_reg == REQ_LOAD_ONE);
                        we_two = (op_reg == REQ_LOAD_TWO);
                        if (op_reg == REQ_LOAD_TWO) begin
                            cnt_two_next = load_base + CNT_W'(1);
                        end else begin
                            cnt_one_next = load_base + CNT_W'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            // Outer loop: fetch the next candidate
            ST_NEXT: begin
                if (!phase_reg) begin
                    if (outer_reg < cnt_one_reg) begin
                        raddr      = outer_reg[ADDR_W-1:0];
                        sel_next   = 1'b0;
                        state_next = ST_CAND;
                    end else if (op_reg == REQ_UNION) begin
                        phase_next = 1'b1;
                        outer_next = '0;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end else begin
                    if (outer_reg < cnt_two_reg) begin
                        raddr      = outer_reg[ADDR_W-1:0];
                        sel_next   = 1'b1;
                        state_next = ST_CAND;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            // Capture candidate and choose which set to scan
            ST_CAND: begin
                cand_next  = rdata_sel;
                hit_next   = 1'b0;
                inner_next = '0;
                pend_next  = 1'b0;
                sub_next   = 1'b0;
                if (op_reg == REQ_UNION && !phase_reg) begin
                    state_next = ST_EMIT;
                end else if (op_reg == REQ_UNION) begin
                    sel_next   = 1'b0;
                    lim_next   = cnt_one_reg;
                    state_next = ST_SCAN;
                end else begin
                    sel_next   = 1'b1;
                    lim_next   = cnt_two_reg;
                    state_next = ST_SCAN;
                end
            end

            // One read issued and one compare done per cycle
            ST_SCAN: begin
                if (pend_reg && rdata_sel == cand_reg) begin
                    hit_next = 1'b1;
                end
                if (inner_reg < lim_reg) begin
                    raddr      = inner_reg[ADDR_W-1:0];
                    inner_next = inner_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (op_reg == REQ_FIND_ONE || op_reg == REQ_FIND_TWO) begin
                            state_next = ST_FINDOUT;
                        end else if (op_reg == REQ_UNION && !sub_reg && !hit_reg) begin
                            // also check the earlier entries of set two
                            sub_next   = 1'b1;
                            sel_next   = 1'b1;
                            lim_next   = outer_reg;
                            inner_next = '0;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            // Hold back one element so that the final one can carry last
            ST_EMIT: begin
                if (!keep) begin
                    outer_next = outer_reg + CNT_W'(1);
                    state_next = ST_NEXT;
                end else if (!hold_valid_reg) begin
                    hold_next       = cand_reg;
                    hold_valid_next = 1'b1;
                    outer_next      = outer_reg + CNT_W'(1);
                    state_next      = ST_NEXT;
                end else if (out_free) begin
                    out_push         = 1'b1;
                    out_item.element = hold_reg;
                    hold_next        = cand_reg;
                    outer_next       = outer_reg + CNT_W'(1);
                    state_next       = ST_NEXT;
                end
            end

            // Final element, or the empty marker
            ST_FLUSH: begin
                if (out_free) begin
                    out_push      = 1'b1;
                    out_item.last = 1'b1;
                    if (hold_valid_reg) begin
                        out_item.element = hold_reg;
                    end else begin
                        out_item.empty_res = 1'b1;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_FINDOUT: begin
                if (out_free) begin
                    out_push         = 1'b1;
                    out_item.element = val_reg;
                    out_item.found   = hit_reg;
                    out_item.last    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_one_reg    <= '0;
            cnt_two_reg    <= '0;
            pend_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_one_reg    <= cnt_one_next;
            cnt_two_reg    <= cnt_two_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        val_reg   <= val_next;
        first_reg <= first_next;
        outer_reg <= outer_next;
        inner_reg <= inner_next;
        lim_reg   <= lim_next;
        hit_reg   <= hit_next;
        cand_reg  <= cand_next;
        phase_reg <= phase_next;
        sub_reg   <= sub_next;
        sel_reg   <= sel_next;
        hold_reg  <= hold_next;
    end

endmodule

`default_nettype wire

FILE: rtl/set_operations_engine.sv
// Top level of the set operations engine: two set memories, the request
// sequencer and the output register. Depends on soe_pkg, soe_ram, soe_ctrl, soe_out.
//
//   channel  | direction | tdata       | tuser                      | tlast
//   ---------+-----------+-------------+----------------------------+------
//   s_       | in        | value       | req_type[2:0], first[3]    | -
//   m_       | out       | element     | found, empty_res, status   | last
//
// A load or a find takes one beat at a time. Set operations read one memory word
// per cycle while they scan: intersection and difference scan set two for each
// element of set one; union streams set one, then checks each element of set two
// against set one and against the earlier entries of set two.
// Each set memory has a single read port.
// Synchronous active-low reset clears the set counts; store contents need no clearing.
// A stalled m_ side holds the sequencer; s_tready is high only between requests.
`timescale 1ns / 1ps
`default_nettype none

module set_operations_engine #(
    parameter int SET_CAPACITY = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value
    input  wire logic [3:0]  s_tuser,   // req_type[2:0], first[3]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // element
    output logic [2:0]       m_tuser,   // found[0], empty_res[1], status[2]
    output logic             m_tlast
);

    import soe_pkg::*;

    localparam int ADDR_W = $clog2(SET_CAPACITY);

    logic              out_free;
    logic              out_push;
    soe_item_t         out_item;
    logic              we_one;
    logic              we_two;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [ELEM_W-1:0] wdata;
    logic [ELEM_W-1:0] rdata_one;
    logic [ELEM_W-1:0] rdata_two;

    // Set stores
    soe_ram #(.WIDTH(ELEM_W), .DEPTH(SET_CAPACITY)) u_set_one (
        .clk   (aclk),
        .we    (we_one),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_one)
    );

    soe_ram #(.WIDTH(ELEM_W), .DEPTH(SET_CAPACITY)) u_set_two (
        .clk   (aclk),
        .we    (we_two),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_two)
    );

    // Sequencer
    soe_ctrl #(.SET_CAPACITY(SET_CAPACITY)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .req_type  (s_tuser[2:0]),
        .value     (s_tdata),
        .first     (s_tuser[3]),
        .out_free  (out_free),
        .out_push  (out_push),
        .out_item  (out_item),
        .we_one    (we_one),
        .we_two    (we_two),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr     (raddr),
        .rdata_one (rdata_one),
        .rdata_two (rdata_two)
    );

    // Result register
    soe_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_item (out_item),
        .push      (out_push),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/soe_checker.sv
// Port-level checks for the set operations engine, bound to the top level.
// Depends on soe_pkg for the request codes.
`timescale 1ns / 1ps
`default_nettype none

module soe_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [3:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    import soe_pkg::*;

    // A real request keeps the input closed in the following cycle
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[2:0] != REQ_NONE |=> !s_tready)
        else $error("input still open after a request beat");

    // Empty marker is a lone zero beat closing the request
    a_empty_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 32'd0 && m_tlast)
        else $error("empty marker beat malformed");

    // At most one of found, empty_res, status per beat
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tuser))
        else $error("conflicting result flags");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed under stall");

endmodule

bind set_operations_engine soe_checker u_soe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: verif/tb_set_operations_engine.sv
// Self-checking testbench for set_operations_engine: sends request beats, predicts
// every result beat from its own copy of both sets and compares them field by field.
// Depends on soe_pkg and the set_operations_engine RTL.
`timescale 1ns / 1ps

module tb_set_operations_engine;
    import soe_pkg::*;

    localparam int     SET_CAP      = 32;
    localparam int     CLK_HALF     = 10;
    localparam int     RESET_CYCLES = 9;
    localparam int     RANDOM_ITEMS = 80;
    localparam int     TAIL_CYCLES  = 200;
    localparam int     MAX_REPORTS  = 40;
    // worst case: ~250 requests, each a full union with 64 beats and long stalls, x4
    localparam longint MAX_CYCLES   = 6000000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // value
    logic [3:0]  s_tuser  = '0;     // req_type[2:0], first[3]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // element
    logic [2:0]  m_tuser;           // found[0], empty_res[1], status[2]
    logic        m_tlast;

    // Predictor copy of the two sets, in stored order
    logic [31:0] set_one_words[$];
    logic [31:0] set_two_words[$];
    // Result beats still owed by the block, oldest first
    soe_item_t   pending_beats[$];

    int unsigned    error_count   = 0;
    int unsigned    beats_checked = 0;
    int unsigned    items_sent    = 0;
    int unsigned    loads_sent    = 0;
    int unsigned    loads_dropped = 0;
    int unsigned    finds_sent    = 0;
    int unsigned    setops_sent   = 0;
    int unsigned    ignored_sent  = 0;
    int unsigned    largest_answer = 0;
    int unsigned    ready_stall   = 0;
    longint unsigned cycle_count  = 0;
    bit             steady_flow   = 1'b0;

    // Clock
    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    set_operations_engine #(
        .SET_CAPACITY(SET_CAP)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Word from a small pool of corner values, or anything at all
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h0000_0002;
            3: return 32'h0000_0003;
            4: return 32'hFFFF_FFFF;
            5: return 32'h8000_0000;
            6: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit has_word(input logic [31:0] pool[$], input logic [31:0] word);
        foreach (pool[i])
            if (pool[i] == word)
                return 1'b1;
        return 1'b0;
    endfunction

    // Work out the answer to one accepted request and queue its beats
    function automatic void predict_request(input logic [REQ_W-1:0] req,
                                            input logic [31:0] word, input logic first);
        soe_item_t   answer[$];
        logic [31:0] given[$];
        soe_item_t   beat;
        beat = '{element: word, found: 1'b0, empty_res: 1'b0, status: 1'b0, last: 1'b1};
        case (req)
            REQ_LOAD_ONE: begin
                if (first)
                    set_one_words.delete();
                if (set_one_words.size() >= SET_CAP)
                    beat.status = 1'b1;
                else
                    set_one_words.push_back(word);
                answer.push_back(beat);
            end
            REQ_LOAD_TWO: begin
                if (first)
                    set_two_words.delete();
                if (set_two_words.size() >= SET_CAP)
                    beat.status = 1'b1;
                else
                    set_two_words.push_back(word);
                answer.push_back(beat);
            end
            REQ_FIND_ONE: begin
                beat.found = has_word(set_one_words, word);
                answer.push_back(beat);
            end
            REQ_FIND_TWO: begin
                beat.found = has_word(set_two_words, word);
                answer.push_back(beat);
            end
            REQ_UNION: begin
                given = set_one_words;
                foreach (set_two_words[i])
                    if (!has_word(given, set_two_words[i]))
                        given.push_back(set_two_words[i]);
            end
            REQ_INTER, REQ_DIFF: begin
                foreach (set_one_words[i])
                    if (has_word(set_two_words, set_one_words[i]) == (req == REQ_INTER))
                        given.push_back(set_one_words[i]);
            end
            default: ;
        endcase

        // set operations stream their elements; no elements gives one empty beat
        if (req == REQ_UNION || req == REQ_INTER || req == REQ_DIFF) begin
            beat.last = 1'b0;
            foreach (given[i]) begin
                beat.element = given[i];
                answer.push_back(beat);
            end
            if (answer.size() == 0) begin
                beat.element   = '0;
                beat.empty_res = 1'b1;
                answer.push_back(beat);
            end
            answer[answer.size()-1].last = 1'b1;
            if (answer.size() > largest_answer)
                largest_answer = answer.size();
        end
        if (beat.status)
            loads_dropped++;
        foreach (answer[i])
            pending_beats.push_back(answer[i]);
    endfunction

    // Send one request beat; s_tvalid stays high if the next one follows at once
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [31:0] word,
                             input logic first);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= {first, req};
        do @(posedge aclk); while (!s_tready);
        predict_request(req, word, first);
        case (req)
            REQ_LOAD_ONE, REQ_LOAD_TWO: loads_sent++;
            REQ_FIND_ONE, REQ_FIND_TWO: finds_sent++;
            REQ_UNION, REQ_INTER, REQ_DIFF: setops_sent++;
            default: ignored_sent++;
        endcase
        if (req != REQ_NONE)
            items_sent++;
    endtask

    // Restart a set and fill it with len words
    task automatic build_set(input logic [REQ_W-1:0] req, input int unsigned len,
                             input bit spread);
        for (int unsigned k = 0; k < len; k++)
            send_item(req, spread ? 32'($urandom) : pick_word(), k == 0);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, field, want, got);
        end
    endtask

    // Result side: check each accepted beat, then choose the next tready
    always @(posedge aclk) begin
        soe_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t ns: result beat with none expected, expected none, actual %h",
                             $time, m_tdata);
            end else begin
                want = pending_beats.pop_front();
                beats_checked++;
                check_field("element", want.element, m_tdata);
                check_field("found", 32'(want.found), 32'(m_tuser[0]));
                check_field("empty_res", 32'(want.empty_res), 32'(m_tuser[1]));
                check_field("status", 32'(want.status), 32'(m_tuser[2]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
        if (ready_stall == 0 && $urandom_range(0, 3) == 0)
            ready_stall = pick_gap();
        if (ready_stall > 0) begin
            m_tready <= 1'b0;
            ready_stall--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("Timeout after %0d cycles, %0d result beats outstanding",
                     cycle_count, pending_beats.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Set operations and lookups straight after reset, both sets empty
    task automatic test_empty_answers();
        send_item(REQ_UNION, 32'h0000_0000, 1'b0);
        send_item(REQ_INTER, 32'hFFFF_FFFF, 1'b1);
        send_item(REQ_DIFF, 32'h0000_0000, 1'b0);
        send_item(REQ_FIND_ONE, 32'h0000_0000, 1'b0);
        send_item(REQ_FIND_TWO, 32'h8000_0000, 1'b1);
    endtask

    // Corner values, duplicates, hits and misses, every operation, unknown code
    task automatic test_directed_requests();
        send_item(REQ_LOAD_ONE, 32'h8000_0000, 1'b1);
        send_item(REQ_LOAD_ONE, 32'h7FFF_FFFF, 1'b0);
        send_item(REQ_LOAD_ONE, 32'h0000_0000, 1'b0);
        send_item(REQ_LOAD_ONE, 32'hFFFF_FFFF, 1'b0);
        send_item(REQ_LOAD_ONE, 32'h0000_0000, 1'b0);   // duplicate kept in set one
        send_item(REQ_LOAD_TWO, 32'hFFFF_FFFF, 1'b1);
        send_item(REQ_LOAD_TWO, 32'h0000_0007, 1'b0);
        send_item(REQ_LOAD_TWO, 32'h0000_0007, 1'b0);   // union must give it once
        send_item(REQ_LOAD_TWO, 32'h7FFF_FFFF, 1'b0);
        send_item(REQ_FIND_ONE, 32'hFFFF_FFFF, 1'b0);
        send_item(REQ_FIND_ONE, 32'hFFFF_FFFE, 1'b1);
        send_item(REQ_FIND_TWO, 32'h0000_0007, 1'b0);
        send_item(REQ_FIND_TWO, 32'h8000_0000, 1'b0);
        send_item(REQ_UNION, 32'h0000_0000, 1'b0);
        send_item(REQ_INTER, 32'h0000_0000, 1'b0);
        send_item(REQ_DIFF, 32'hFFFF_FFFF, 1'b1);
        send_item(REQ_NONE, 32'h1234_5678, 1'b1);
        // set one restarted to {7}: difference empty, intersection not
        send_item(REQ_LOAD_ONE, 32'h0000_0007, 1'b1);
        send_item(REQ_DIFF, 32'h0000_0000, 1'b0);
        send_item(REQ_INTER, 32'h0000_0000, 1'b0);
        send_item(REQ_LOAD_TWO, 32'h8000_0000, 1'b1);
        send_item(REQ_INTER, 32'h0000_0000, 1'b0);
    endtask

    // Both sets filled to capacity, appends dropped, longest answers
    task automatic test_set_capacity();
        build_set(REQ_LOAD_ONE, SET_CAP + 2, 1'b1);
        build_set(REQ_LOAD_TWO, SET_CAP + 1, 1'b1);
        send_item(REQ_UNION, 32'h0000_0000, 1'b0);
        send_item(REQ_FIND_TWO, set_two_words[SET_CAP-1], 1'b0);
        send_item(REQ_INTER, 32'h0000_0000, 1'b0);
        send_item(REQ_DIFF, 32'h0000_0000, 1'b0);
        // restart on a full set always succeeds
        send_item(REQ_LOAD_ONE, 32'h7FFF_FFFF, 1'b1);
    endtask

    // Mostly set builds with lookups and set operations, some noise
    task automatic test_random_traffic();
        int unsigned      sel;
        int unsigned      len;
        int unsigned      target;
        logic [31:0]      word;
        logic [REQ_W-1:0] req;
        bit               paused;
        target = items_sent + RANDOM_ITEMS;
        paused = 1'b0;
        while (items_sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                len = ($urandom_range(0, 14) == 0) ? $urandom_range(SET_CAP - 2, SET_CAP + 2)
                                                   : $urandom_range(1, 6);
                build_set($urandom_range(0, 1) ? REQ_LOAD_TWO : REQ_LOAD_ONE, len,
                          $urandom_range(0, 3) == 0);
            end else if (sel < 45) begin
                req  = $urandom_range(0, 1) ? REQ_FIND_TWO : REQ_FIND_ONE;
                word = pick_word();
                if (req == REQ_FIND_ONE && set_one_words.size() > 0 && $urandom_range(0, 1))
                    word = set_one_words[$urandom_range(0, set_one_words.size() - 1)];
                if (req == REQ_FIND_TWO && set_two_words.size() > 0 && $urandom_range(0, 1))
                    word = set_two_words[$urandom_range(0, set_two_words.size() - 1)];
                send_item(req, word, 1'($urandom_range(0, 1)));
            end else if (sel < 60) begin
                case ($urandom_range(0, 2))
                    0: req = REQ_UNION;
                    1: req = REQ_INTER;
                    default: req = REQ_DIFF;
                endcase
                send_item(req, $urandom, 1'($urandom_range(0, 1)));
            end else if (sel < 85) begin
                send_item($urandom_range(0, 1) ? REQ_LOAD_TWO : REQ_LOAD_ONE, pick_word(),
                          $urandom_range(0, 7) == 0);
            end else if (sel < 95) begin
                send_item(REQ_NONE, $urandom, 1'($urandom_range(0, 1)));
            end else begin
                send_item(3'($urandom_range(0, 7)), $urandom, 1'($urandom_range(0, 1)));
            end

            // hold the sender once until every answer is out
            if (!paused && items_sent + RANDOM_ITEMS / 2 >= target) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_beats.size() != 0);
            end
            // a stretch with no idling on either side
            steady_flow = (items_sent + 70 >= target) && (items_sent + 40 < target);
        end
        steady_flow = 1'b0;
    endtask

    // Sequence of tests and the verdict
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_answers();
        test_directed_requests();
        test_set_capacity();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d loads (%0d dropped on a full set), %0d lookups,",
                 loads_sent, loads_dropped, finds_sent);
        $display("%0d set ops, %0d unknown codes; checked %0d result beats, longest %0d",
                 setops_sent, ignored_sent, beats_checked, largest_answer);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/soe_pkg.sv
rtl/soe_ram.sv
rtl/soe_out.sv
rtl/soe_ctrl.sv
rtl/set_operations_engine.sv
rtl/soe_checker.sv
verif/tb_set_operations_engine.sv
